// ----- sv/binary_to_decimal_ascii_core_defines.svh -----
// Assertion macros used by bdac_emit.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define BDAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define BDAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BDAC_ASSERT(lbl, prop, msg)
`define BDAC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/bdac_pkg.sv -----
package bdac_pkg;

  localparam int VALUE_BITS = 32;

  // Decimal digits needed for the largest value of the given width.
  function automatic int dec_digits(input int bits);
    logic [64:0] m;
    int          n;
    m = (65'd1 << bits) - 65'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (m != '0) begin
        n++;
        m = m / 65'd10;
      end
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = dec_digits(VALUE_BITS);
  localparam int DIDX_W     = $clog2(NUM_DIGITS);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CHAR_W     = 6;
  localparam int OUT_DATA_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // One converted value: its BCD digits and the index of the leading digit.
  typedef struct packed {
    bcd_t              digits;
    logic [DIDX_W-1:0] msd;
  } bdac_entry_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic valid;
  } bdac_qstat_t;

  // Add three to every digit of five or more, ahead of the shift.
  function automatic bcd_t dd_adjust(input bcd_t b);
    bcd_t r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[i] >= 4'd5) begin
        r[i] = b[i] + 4'd3;
      end
    end
    return r;
  endfunction

  // Index of the highest non-zero digit; zero when all digits are zero.
  function automatic logic [DIDX_W-1:0] msd_index(input bcd_t b);
    logic [DIDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[i] != 4'd0) begin
        idx = DIDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/binary_to_decimal_ascii_core.sv -----
// Binary to decimal ASCII converter. Each input beat carries one unsigned
// 32-bit value in in_tdata; the block answers with its decimal text, one
// ASCII digit per output beat, most significant digit first and with leading
// zeros dropped (zero gives the single character '0'). out_tlast is high on
// the least significant digit of each value, so one value maps to one frame
// of one to ten beats. The front end takes a value in S_IDLE, runs 32
// shift-add-3 steps in S_CONV (one per input bit, the loop that sets the
// rate) and in S_PUSH hands the BCD word to a two-entry queue. The back
// end drains the queue at one character per cycle within a value while the
// sink keeps up, as the front end converts the next value; the front end
// takes no new value until the last one is pushed. Upper tdata bits beyond
// the value width are ignored. Reset is synchronous, active low, and clears
// control state only.
module binary_to_decimal_ascii_core
  import bdac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                  out_tlast   // last_digit
);

  bdac_qstat_t q_stat;
  bdac_entry_t q_wdata;
  bdac_entry_t q_rdata;
  logic        q_push;
  logic        q_pop;

  // Front end: accept a value and run the double-dabble loop.
  bdac_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Hold converted values so either side can stall on its own.
  bdac_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: walk the digits down from the leading one, one beat each.
  bdac_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sv/bdac_conv.sv -----
module bdac_conv
  import bdac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // value
  input  bdac_qstat_t          q_stat,
  output logic                 q_push,
  output bdac_entry_t          q_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_PUSH} state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]  bin_r, bin_nxt;
  bcd_t                   bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BCD_W-1:0]       adj_flat;

  assign in_tready       = (state_r == S_IDLE);
  assign q_push          = (state_r == S_PUSH) && !q_stat.full;
  assign q_wdata.digits  = bcd_r;
  assign q_wdata.msd     = msd_index(bcd_r);
  assign adj_flat        = dd_adjust(bcd_r);

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          bin_nxt   = in_tdata[VALUE_BITS-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = BIT_CNT_W'(VALUE_BITS - 1);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // Adjust, then shift one binary bit into the BCD word.
        bcd_nxt = {adj_flat[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ----- sv/bdac_queue.sv -----
module bdac_queue
  import bdac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bdac_entry_t wdata,
  input  logic        pop,
  output bdac_entry_t rdata,
  output bdac_qstat_t stat
);

  bdac_entry_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/bdac_emit.sv -----
`include "binary_to_decimal_ascii_core_defines.svh"

module bdac_emit
  import bdac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdac_qstat_t           q_stat,
  input  bdac_entry_t           q_rdata,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // digit_char, zero pad
  output logic                  out_tlast   // last_digit
);

  logic              busy_r, busy_nxt;
  bcd_t              digits_r, digits_nxt;
  logic [DIDX_W-1:0] pos_r, pos_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              slot_free;

  assign slot_free  = !ov_r || out_tready;
  assign q_pop      = !busy_r && q_stat.valid;
  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, char_r};
  assign out_tlast  = last_r;

  always_comb begin
    busy_nxt   = busy_r;
    digits_nxt = digits_r;
    pos_nxt    = pos_r;
    ov_nxt     = ov_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    if (!busy_r) begin
      // Take the next converted value, leading digit first.
      if (q_stat.valid) begin
        digits_nxt = q_rdata.digits;
        pos_nxt    = q_rdata.msd;
        busy_nxt   = 1'b1;
      end
    end else if (slot_free) begin
      ov_nxt   = 1'b1;
      char_nxt = ASCII_ZERO + {{(CHAR_W - 4){1'b0}}, digits_r[pos_r]};
      last_nxt = (pos_r == '0);
      if (pos_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    digits_r <= digits_nxt;
    pos_r    <= pos_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  // A value finishes only by loading its last character.
  `BDAC_ASSERT(a_done_on_last, $fell(busy_r) |-> (ov_r && last_r), "value ended without last beat")
  // Digit position stays inside the BCD word.
  `BDAC_ASSERT(a_pos_range, busy_r |-> (pos_r < DIDX_W'(NUM_DIGITS)), "digit position out of range")
  // Every shown character is a decimal digit.
  `BDAC_ASSERT(a_char_digit, ov_r |-> (char_r >= ASCII_ZERO && char_r <= ASCII_ZERO + 6'd9), "non-digit character")
  // A popped entry starts an emission run.
  `BDAC_ASSERT(a_pop_busy, q_pop |=> busy_r, "pop did not start emission")

endmodule
